// ===== rtl/core/sgf_pkg.sv =====
// Shared types and constants for the scan gap fill / nearest object block.
package sgf_pkg;

   localparam int DIST_W = 16;
   localparam int ANG_W  = 9;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [DIST_W-1:0] MIN_DIST_RST  = 16'd0;
   localparam logic [DIST_W-1:0] MAX_DIST_RST  = 16'd65535;
   localparam logic [DIST_W-1:0] THRESHOLD_RST = 16'd100;

   typedef struct packed {
      logic clr;
      logic push;
      logic pick_lo;
      logic pick_hi;
   } med_ctl_type;

endpackage

// ===== rtl/core/scan_gap_fill_nearest_object.sv =====
// Top level: scan store, gap fill, nearest object search and edge walks.
//
// Usage: the req_ channel takes one sample per beat (start high while busy is
// low). Each sample is written to the raw scan memory at req_angle_index when
// accepted; indexes at or beyond NUM_ANGLES store nothing. A beat with
// req_last_sample set ends the scan and starts processing, holding busy high:
//   gap fill      per angle, one window read per cycle from the raw memory's
//                 single read port, then a median pick and a filtered write
//   nearest search one pass over the filtered memory
//   edge walks    a read and a check state per visited angle, forward then
//                 backward from the nearest angle, after a reference read
// One result beat then appears on the rsp_ ports with rsp_valid high for one
// cycle; the receiver cannot stall it. Ordinary samples do not raise busy. The
// csr_ channel is always ready; registers are to be written only while idle,
// which the block does not enforce. Reset clears the sequencer and loads the
// register defaults; scan memories are not cleared and hold garbage until written.
module scan_gap_fill_nearest_object
   import sgf_pkg::*;
#(
   parameter int NUM_ANGLES = 360,
   parameter int WINDOW_LEN = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ANG_W-1:0]     req_angle_index,
   input  logic [DIST_W-1:0]    req_distance,
   input  logic                 req_last_sample,
   output logic                 rsp_valid,
   output logic [DIST_W-1:0]    rsp_nearest_distance,
   output logic [ANG_W-1:0]     rsp_left_angle,
   output logic [ANG_W-1:0]     rsp_right_angle,
   output logic [ANG_W-1:0]     rsp_mid_angle,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_wdata
);

   localparam int AW   = $clog2(NUM_ANGLES);
   localparam int IW   = $clog2(NUM_ANGLES + 1);
   localparam int KW   = $clog2(WINDOW_LEN + 1);
   localparam int HALF = WINDOW_LEN / 2;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FILT   = 4'd1;
   localparam logic [3:0] S_PLO    = 4'd2;
   localparam logic [3:0] S_PHI    = 4'd3;
   localparam logic [3:0] S_FWR    = 4'd4;
   localparam logic [3:0] S_SRCH   = 4'd5;
   localparam logic [3:0] S_REF_RD = 4'd6;
   localparam logic [3:0] S_REF_WT = 4'd7;
   localparam logic [3:0] S_FWD_RD = 4'd8;
   localparam logic [3:0] S_FWD_CK = 4'd9;
   localparam logic [3:0] S_BWD_RD = 4'd10;
   localparam logic [3:0] S_BWD_CK = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   logic [3:0]        state_ff, state_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [KW-1:0]     k_ff, k_in;
   logic [DIST_W-1:0] center_ff, center_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [AW-1:0]     best_ang_ff, best_ang_in;
   logic [DIST_W-1:0] ref_ff, ref_in;
   logic [AW-1:0]     cmp_ff, cmp_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [AW-1:0]     start_ff, start_in;

   logic [DIST_W-1:0] min_dist_ff, max_dist_ff, thresh_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [ANG_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [ANG_W-1:0]  rsp_end_ff, rsp_end_in;
   logic [ANG_W-1:0]  rsp_mid_ff, rsp_mid_in;

   logic              raw_we;
   logic [AW-1:0]     raw_raddr;
   logic [DIST_W-1:0] raw_rdata;
   logic              filt_we;
   logic [DIST_W-1:0] filt_wdata;
   logic [AW-1:0]     filt_raddr;
   logic [DIST_W-1:0] filt_rdata;

   med_ctl_type       med_ctl;
   logic [DIST_W-1:0] median;

   logic              accept;
   logic [AW+1:0]     win_t0, win_t1, win_t2;
   logic [AW-1:0]     ang_prev;
   logic [DIST_W-1:0] diff;
   logic [AW-1:0]     cmp_inc, cmp_dec, best_dec;
   logic [AW:0]       end_ext;
   logic [AW+1:0]     mid_sum;
   logic [AW:0]       mid_half, mid_wrap;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign raw_we = accept && ({2'b00, req_angle_index} < 11'(NUM_ANGLES));

   sgf_ram #(.WIDTH(DIST_W), .DEPTH(NUM_ANGLES)) u_raw_ram (
      .clock (clock),
      .we    (raw_we),
      .waddr (AW'(req_angle_index)),
      .wdata (req_distance),
      .raddr (raw_raddr),
      .rdata (raw_rdata)
   );

   sgf_ram #(.WIDTH(DIST_W), .DEPTH(NUM_ANGLES)) u_filt_ram (
      .clock (clock),
      .we    (filt_we),
      .waddr (i_ff[AW-1:0]),
      .wdata (filt_wdata),
      .raddr (filt_raddr),
      .rdata (filt_rdata)
   );

   sgf_median #(.WINDOW_LEN(WINDOW_LEN)) u_median (
      .clock  (clock),
      .reset  (reset),
      .ctl    (med_ctl),
      .din    (raw_rdata),
      .median (median)
   );

   // circular window address: i + k - HALF, biased by NUM_ANGLES to stay positive
   assign win_t0 = (AW+2)'(i_ff[AW-1:0]) + (AW+2)'(k_ff) + (AW+2)'(NUM_ANGLES - HALF);
   assign win_t1 = (win_t0 >= (AW+2)'(NUM_ANGLES)) ? win_t0 - (AW+2)'(NUM_ANGLES) : win_t0;
   assign win_t2 = (win_t1 >= (AW+2)'(NUM_ANGLES)) ? win_t1 - (AW+2)'(NUM_ANGLES) : win_t1;
   assign raw_raddr = win_t2[AW-1:0];

   assign ang_prev = AW'(i_ff - 1'b1);
   assign diff     = (ref_ff > filt_rdata) ? ref_ff - filt_rdata : filt_rdata - ref_ff;
   assign cmp_inc  = (cmp_ff == AW'(NUM_ANGLES - 1)) ? '0 : cmp_ff + 1'b1;
   assign cmp_dec  = (cmp_ff == '0) ? AW'(NUM_ANGLES - 1) : cmp_ff - 1'b1;
   assign best_dec = (best_ang_ff == '0) ? AW'(NUM_ANGLES - 1) : best_ang_ff - 1'b1;

   assign end_ext  = (end_ff < start_ff) ? (AW+1)'(end_ff) + (AW+1)'(NUM_ANGLES)
                                         : (AW+1)'(end_ff);
   assign mid_sum  = (AW+2)'(start_ff) + (AW+2)'(end_ext);
   assign mid_half = mid_sum[AW+1:1];
   assign mid_wrap = (mid_half >= (AW+1)'(NUM_ANGLES)) ? mid_half - (AW+1)'(NUM_ANGLES)
                                                       : mid_half;

   assign filt_wdata = (center_ff != '0) ? center_ff : median;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      center_in    = center_ff;
      best_dist_in = best_dist_ff;
      best_ang_in  = best_ang_ff;
      ref_in       = ref_ff;
      cmp_in       = cmp_ff;
      end_in       = end_ff;
      start_in     = start_ff;
      rsp_valid_in = 1'b0;
      rsp_dist_in  = rsp_dist_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_mid_in   = rsp_mid_ff;
      med_ctl      = '0;
      filt_we      = 1'b0;
      filt_raddr   = i_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_last_sample) begin
               i_in        = '0;
               k_in        = '0;
               med_ctl.clr = 1'b1;
               state_in    = S_FILT;
            end
         end
         S_FILT: begin
            // data of window slot k-1 arrives while slot k is issued
            if (k_ff != '0) begin
               med_ctl.push = (raw_rdata != '0);
               if (k_ff - 1'b1 == KW'(HALF)) begin
                  center_in = raw_rdata;
               end
            end
            if (k_ff == KW'(WINDOW_LEN)) begin
               state_in = S_PLO;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_PLO: begin
            med_ctl.pick_lo = 1'b1;
            state_in        = S_PHI;
         end
         S_PHI: begin
            med_ctl.pick_hi = 1'b1;
            state_in        = S_FWR;
         end
         S_FWR: begin
            filt_we     = 1'b1;
            med_ctl.clr = 1'b1;
            k_in        = '0;
            if (i_ff == IW'(NUM_ANGLES - 1)) begin
               i_in         = '0;
               best_dist_in = max_dist_ff;
               best_ang_in  = '0;
               state_in     = S_SRCH;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_FILT;
            end
         end
         S_SRCH: begin
            if (i_ff != '0) begin
               if (filt_rdata > min_dist_ff && filt_rdata < best_dist_ff) begin
                  best_dist_in = filt_rdata;
                  best_ang_in  = ang_prev;
               end
            end
            if (i_ff == IW'(NUM_ANGLES)) begin
               state_in = S_REF_RD;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_REF_RD: begin
            filt_raddr = best_ang_ff;
            state_in   = S_REF_WT;
         end
         S_REF_WT: begin
            ref_in   = filt_rdata;
            cmp_in   = best_ang_ff;
            state_in = S_FWD_RD;
         end
         S_FWD_RD: begin
            filt_raddr = cmp_ff;
            state_in   = S_FWD_CK;
         end
         S_FWD_CK: begin
            if (diff >= thresh_ff) begin
               end_in   = cmp_ff;
               cmp_in   = best_dec;
               state_in = S_BWD_RD;
            end else if (cmp_inc == best_ang_ff) begin
               end_in   = cmp_inc;
               cmp_in   = best_dec;
               state_in = S_BWD_RD;
            end else begin
               cmp_in   = cmp_inc;
               state_in = S_FWD_RD;
            end
         end
         S_BWD_RD: begin
            filt_raddr = cmp_ff;
            state_in   = S_BWD_CK;
         end
         S_BWD_CK: begin
            if (diff >= thresh_ff) begin
               start_in = cmp_ff;
               state_in = S_OUT;
            end else if (cmp_dec == best_ang_ff) begin
               start_in = cmp_dec;
               state_in = S_OUT;
            end else begin
               cmp_in   = cmp_dec;
               state_in = S_BWD_RD;
            end
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_dist_in  = best_dist_ff;
            rsp_start_in = ANG_W'(start_ff);
            rsp_end_in   = ANG_W'(end_ff);
            rsp_mid_in   = ANG_W'(mid_wrap);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         min_dist_ff  <= MIN_DIST_RST;
         max_dist_ff  <= MAX_DIST_RST;
         thresh_ff    <= THRESHOLD_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_DIST:  min_dist_ff <= csr_wdata;
               CSR_MAX_DIST:  max_dist_ff <= csr_wdata;
               CSR_THRESHOLD: thresh_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      k_ff         <= k_in;
      center_ff    <= center_in;
      best_dist_ff <= best_dist_in;
      best_ang_ff  <= best_ang_in;
      ref_ff       <= ref_in;
      cmp_ff       <= cmp_in;
      end_ff       <= end_in;
      start_ff     <= start_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_mid_ff   <= rsp_mid_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_nearest_distance = rsp_dist_ff;
   assign rsp_left_angle       = rsp_start_ff;
   assign rsp_right_angle      = rsp_end_ff;
   assign rsp_mid_angle        = rsp_mid_ff;

endmodule

// ===== rtl/core/sgf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module sgf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 360
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/sgf_median.sv =====
// Window median unit: insertion sort of the pushed samples, then a two-step pick.
module sgf_median
   import sgf_pkg::*;
#(
   parameter int WINDOW_LEN = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  med_ctl_type       ctl,
   input  logic [DIST_W-1:0] din,
   output logic [DIST_W-1:0] median
);

   localparam int CW = $clog2(WINDOW_LEN + 1);
   localparam int SW = $clog2(WINDOW_LEN);

   logic [DIST_W-1:0] sorted_ff [WINDOW_LEN];
   logic [DIST_W-1:0] sorted_in [WINDOW_LEN];
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     pos;
   logic [CW-1:0]     half_cnt;
   logic [CW-1:0]     lo_idx;
   logic [SW-1:0]     pick_idx;
   logic [DIST_W-1:0] pick_val;
   logic [DIST_W-1:0] lo_ff;
   logic [DIST_W-1:0] hi_ff;
   logic [DIST_W:0]   pair_sum;

   // insertion point: number of held entries not above the new one
   always_comb begin
      pos = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if (CW'(j) < cnt_ff && sorted_ff[j] <= din) begin
            pos = pos + 1'b1;
         end
      end
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if (CW'(j) < pos) begin
            sorted_in[j] = sorted_ff[j];
         end else if (CW'(j) == pos) begin
            sorted_in[j] = din;
         end else begin
            sorted_in[j] = sorted_ff[(j > 0) ? j - 1 : 0];
         end
      end
   end

   assign half_cnt = cnt_ff >> 1;
   assign lo_idx   = cnt_ff[0] ? half_cnt : half_cnt - 1'b1;
   assign pick_idx = ctl.pick_hi ? half_cnt[SW-1:0] : lo_idx[SW-1:0];

   always_comb begin
      pick_val = '0;
      for (int j = 0; j < WINDOW_LEN; j++) begin
         if (pick_idx == SW'(j)) begin
            pick_val = sorted_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.clr) begin
         cnt_ff <= '0;
      end else if (ctl.push && cnt_ff < CW'(WINDOW_LEN)) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !ctl.clr && cnt_ff < CW'(WINDOW_LEN)) begin
         sorted_ff <= sorted_in;
      end
      if (ctl.pick_lo) begin
         lo_ff <= pick_val;
      end
      if (ctl.pick_hi) begin
         hi_ff <= pick_val;
      end
   end

   assign pair_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign median   = (cnt_ff == '0) ? '0 : pair_sum[DIST_W:1];

endmodule

// ===== test/scan_gap_fill_nearest_object_tb.sv =====
// Testbench for scan_gap_fill_nearest_object: directed and random scans checked against a built-in predictor.
module scan_gap_fill_nearest_object_tb;
   import sgf_pkg::*;

   localparam int NANG = 360;
   localparam int WIN = 5;
   localparam int STALL_LIMIT = 40000;

   typedef struct packed {
      logic [DIST_W-1:0] near_d;
      logic [ANG_W-1:0]  a_start;
      logic [ANG_W-1:0]  a_end;
      logic [ANG_W-1:0]  a_mid;
   } object_type;

   logic clock, reset, start, busy;
   logic [ANG_W-1:0] req_angle_index;
   logic [DIST_W-1:0] req_distance;
   logic req_last_sample;
   logic rsp_valid;
   logic [DIST_W-1:0] rsp_nearest_distance;
   logic [ANG_W-1:0] rsp_left_angle, rsp_right_angle, rsp_mid_angle;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIST_W-1:0] csr_wdata;

   scan_gap_fill_nearest_object dut (.*);

   // predictor state
   logic [DIST_W-1:0] scan_mem [NANG];
   logic [DIST_W-1:0] fill_mem [NANG];
   logic [DIST_W-1:0] lim_min, lim_max, edge_thr;
   object_type objects_due[$];

   int errors = 0;
   int samples_sent = 0;
   int scans_done = 0;
   int objects_seen = 0;
   int stall_cycles = 0;
   bit no_gaps = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic logic [DIST_W-1:0] gap_median(int pos);
      logic [DIST_W-1:0] w [WIN];
      logic [DIST_W-1:0] t;
      int cnt, idx;
      cnt = 0;
      for (int k = -(WIN / 2); k <= WIN / 2; k++) begin
         idx = (pos + k + NANG) % NANG;
         if (scan_mem[idx] != 0) begin
            w[cnt] = scan_mem[idx];
            cnt++;
         end
      end
      if (cnt == 0) return '0;
      for (int a = 0; a < cnt - 1; a++)
         for (int b = a + 1; b < cnt; b++)
            if (w[a] > w[b]) begin
               t = w[a]; w[a] = w[b]; w[b] = t;
            end
      if (cnt % 2 == 0) return DIST_W'(({1'b0, w[cnt/2-1]} + {1'b0, w[cnt/2]}) >> 1);
      return w[cnt/2];
   endfunction

   function automatic int dist_gap(logic [DIST_W-1:0] x, logic [DIST_W-1:0] y);
      return (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
   endfunction

   function automatic object_type find_object();
      object_type o;
      logic [DIST_W-1:0] best, ref_d;
      int best_a, c, s, e, m;
      for (int i = 0; i < NANG; i++)
         fill_mem[i] = (scan_mem[i] != 0) ? scan_mem[i] : gap_median(i);
      best = lim_max;
      best_a = 0;
      for (int i = 0; i < NANG; i++)
         if (fill_mem[i] > lim_min && fill_mem[i] < best) begin
            best = fill_mem[i];
            best_a = i;
         end
      ref_d = fill_mem[best_a];
      c = best_a;
      while (dist_gap(ref_d, fill_mem[c]) < int'(edge_thr)) begin
         c = (c + 1) % NANG;
         if (c == best_a) break;
      end
      e = c;
      c = (best_a == 0) ? NANG - 1 : best_a - 1;
      while (dist_gap(ref_d, fill_mem[c]) < int'(edge_thr)) begin
         c = (c == 0) ? NANG - 1 : c - 1;
         if (c == best_a) break;
      end
      s = c;
      m = (s + ((e < s) ? e + NANG : e)) / 2;
      if (m >= NANG) m -= NANG;
      o.near_d = best;
      o.a_start = ANG_W'(s);
      o.a_end = ANG_W'(e);
      o.a_mid = ANG_W'(m);
      return o;
   endfunction

   // one sample beat; prediction happens at acceptance of a last sample
   task automatic send_sample(int ang, logic [DIST_W-1:0] d, bit last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_angle_index <= ANG_W'(ang);
      req_distance <= d;
      req_last_sample <= last;
      do @(posedge clock); while (busy);
      if (ang < NANG) scan_mem[ang] = d;
      samples_sent++;
      if (last) begin
         objects_due.push_back(find_object());
         scans_done++;
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (objects_due.size() != 0 || busy);
      repeat (8) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after its last beat
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [DIST_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MIN_DIST:  lim_min = v;
         CSR_MAX_DIST:  lim_max = v;
         CSR_THRESHOLD: edge_thr = v;
         default: ;
      endcase
   endtask

   task automatic set_limits(logic [DIST_W-1:0] mn, logic [DIST_W-1:0] mx,
                             logic [DIST_W-1:0] th);
      wait_idle();
      write_csr(CSR_MIN_DIST, mn);
      write_csr(CSR_MAX_DIST, mx);
      write_csr(CSR_THRESHOLD, th);
      csr_valid <= 1'b0;
   endtask

   // an object: a close cluster over a far background, a few dropouts
   task automatic send_object_scan(int n);
      int base, span, a;
      logic [DIST_W-1:0] far_d, near_d, d;
      base = $urandom_range(0, NANG - 1);
      span = $urandom_range(1, 12);
      far_d = DIST_W'($urandom_range(2000, 60000));
      near_d = DIST_W'($urandom_range(1, 1999));
      for (int i = 0; i < n; i++) begin
         a = (base + i) % NANG;
         if ($urandom_range(0, 9) == 0) d = '0;
         else if (i >= 3 && i < 3 + span) d = near_d + DIST_W'($urandom_range(0, 60));
         else d = far_d + DIST_W'($urandom_range(0, 60));
         send_sample(a, d, i == n - 1);
      end
   endtask

   task automatic send_noise_scan(int n);
      int a;
      logic [DIST_W-1:0] d;
      for (int i = 0; i < n; i++) begin
         a = ($urandom_range(0, 15) == 0) ? $urandom_range(NANG, 511)
                                           : $urandom_range(0, NANG - 1);
         case ($urandom_range(0, 3))
            0: d = '0;
            1: d = DIST_W'($urandom);
            default: d = DIST_W'($urandom_range(1, 3000));
         endcase
         send_sample(a, d, i == n - 1);
      end
   endtask

   // fill every angle once so no processing ever sees an unwritten entry
   task automatic test_first_full_scan();
      logic [DIST_W-1:0] d;
      for (int a = 0; a < NANG; a++) begin
         if (a == 0) d = 16'hFFFF;
         else if (a == 1 || (a >= 100 && a < 107)) d = '0;  // 103 has an empty window
         else if (a == 2) d = 16'd1;
         else if (a >= 200 && a < 210) d = 16'd400 + DIST_W'(a);
         else d = 16'd5000 + DIST_W'($urandom_range(0, 150));
         send_sample(a, d, a == NANG - 1);
      end
   endtask

   task automatic test_directed_corners();
      send_sample(511, 16'h1234, 1'b1);           // out of range, still processes
      send_sample(359, 16'hFFFF, 1'b1);
      send_sample(256, 16'h8000, 1'b1);
      set_limits(16'd0, 16'd65535, 16'd0);        // zero threshold
      send_sample(10, 16'd3, 1'b1);
      set_limits(16'd0, 16'd65535, 16'd65535);    // walks go full circle
      send_sample(20, 16'd7, 1'b1);
      set_limits(16'd65535, 16'd65535, 16'd100);  // nothing qualifies
      send_sample(30, 16'd9, 1'b1);
      set_limits(16'd0, 16'd0, 16'd1);
      send_sample(40, 16'd0, 1'b1);
      set_limits(16'd0, 16'd1, 16'd65535);
      send_sample(41, 16'd0, 1'b1);
      set_limits(16'd500, 16'd5200, 16'd200);
      send_sample(205, 16'd0, 1'b0);
      send_sample(206, 16'd0, 1'b1);
   endtask

   task automatic test_random_scans();
      int k;
      k = 0;
      while (samples_sent < 950) begin
         if (k % 8 == 0) begin
            case ($urandom_range(0, 4))
               0: set_limits(16'd0, 16'd65535, 16'd100);
               1: set_limits(16'd0, 16'd65535, DIST_W'($urandom_range(0, 3)));
               2: set_limits(DIST_W'($urandom_range(0, 1500)), DIST_W'($urandom_range(1500, 65535)),
                             DIST_W'($urandom_range(20, 400)));
               3: set_limits(DIST_W'($urandom), DIST_W'($urandom), DIST_W'($urandom));
               default: set_limits(16'd0, 16'd65535, 16'd65535);
            endcase
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         if ($urandom_range(0, 3) != 0) send_object_scan($urandom_range(1, 24));
         else send_noise_scan($urandom_range(1, 12));
         k++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         objects_seen++;
         if (objects_due.size() == 0) begin
            $display("%0t: unexpected result dist=%0d left=%0d right=%0d mid=%0d", $time,
                     rsp_nearest_distance, rsp_left_angle, rsp_right_angle, rsp_mid_angle);
            errors++;
         end else begin
            object_type x;
            x = objects_due.pop_front();
            if (rsp_nearest_distance !== x.near_d) begin
               $display("%0t: nearest_distance exp %0d got %0d", $time, x.near_d,
                        rsp_nearest_distance);
               errors++;
            end
            if (rsp_left_angle !== x.a_start) begin
               $display("%0t: left angle exp %0d got %0d", $time, x.a_start, rsp_left_angle);
               errors++;
            end
            if (rsp_right_angle !== x.a_end) begin
               $display("%0t: right angle exp %0d got %0d", $time, x.a_end, rsp_right_angle);
               errors++;
            end
            if (rsp_mid_angle !== x.a_mid) begin
               $display("%0t: mid angle exp %0d got %0d", $time, x.a_mid,
                        rsp_mid_angle);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired, %0d results pending", $time, objects_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_angle_index = '0;
      req_distance = '0;
      req_last_sample = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      lim_min = MIN_DIST_RST;
      lim_max = MAX_DIST_RST;
      edge_thr = THRESHOLD_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_full_scan();
      test_directed_corners();
      test_random_scans();
      wait_idle();
      repeat (50) @(posedge clock);
      $display("Covered %0d sample beats in %0d scans, %0d results checked.",
               samples_sent, scans_done, objects_seen);
      if (errors == 0 && objects_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, objects_due.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
